>>> rtl/core/xbr_pkg.sv
package xbr_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_MANY = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Bound count codes.
  localparam logic [1:0] BC_RAW  = 2'd0;
  localparam logic [1:0] BC_HIGH = 2'd1;
  localparam logic [1:0] BC_BOTH = 2'd2;
  localparam logic [1:0] BC_MANY = 2'd3;

  // Generator constants.
  localparam logic [31:0] ZERO_SUBST = 32'h6d2b79f5;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  // One remainder step per bit of the 32-bit draw.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic load;     // accept an input transaction and advance the generator
    logic seed_wr;  // reseed the generator
    logic step;     // one restoring remainder step
    logic emit;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic need_div;  // accepted request needs range reduction
  } sts_t;

endpackage

>>> rtl/core/xbr_in_if.sv
interface xbr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         bound_count;
  logic signed [63:0] low_bound;
  logic signed [63:0] high_bound;

  modport source (output valid, bound_count, low_bound, high_bound, input ready);
  modport sink   (input valid, bound_count, low_bound, high_bound, output ready);
endinterface

>>> rtl/core/xbr_out_if.sv
interface xbr_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

>>> rtl/core/xbr_cfg_if.sv
interface xbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

>>> rtl/core/xbr_ctrl.sv
module xbr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  xbr_pkg::sts_t sts,
  output xbr_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  localparam logic [xbr_pkg::CNT_W-1:0] CNT_LAST = xbr_pkg::CNT_W'(xbr_pkg::DIV_STEPS - 1);

  logic [1:0]                state_r, state_nxt;
  logic [xbr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = in_valid & in_ready;
    cmd.seed_wr = cfg_valid & cfg_ready;
    cmd.step    = (state_r == S_DIV);
    cmd.emit    = (state_r == S_HOLD) & (~out_valid_r | out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (cmd.load) begin
          state_nxt = sts.need_div ? S_DIV : S_HOLD;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (cmd.emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/xbr_dp.sv
module xbr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  xbr_pkg::cmd_t      cmd,
  output xbr_pkg::sts_t      sts,
  input  logic [1:0]         bound_count,
  input  logic signed [63:0] low_bound,
  input  logic signed [63:0] high_bound,
  input  logic [31:0]        seed,
  output logic signed [32:0] value,
  output logic [1:0]         status
);

  logic [31:0] gen_r, gen_nxt;
  logic [31:0] xs_r, rem_r, low_r;
  logic [32:0] span_r;
  logic [1:0]  sts_r, status_r;
  logic        raw_r;
  logic [32:0] value_r;

  logic [31:0] x0, x1, x2, x3;
  logic [63:0] lo64;
  logic        lo_ok, hi_ok;
  logic [31:0] lo32, hi32;
  logic [1:0]  chk;
  logic        need_div;
  logic [32:0] span_c;
  logic [32:0] trial, diff;
  logic        ge;
  logic [32:0] result;

  // Xorshift advance; a zero state is replaced before the shifts.
  always_comb begin
    x0 = (gen_r == '0) ? xbr_pkg::ZERO_SUBST : gen_r;
    x1 = x0 ^ (x0 << xbr_pkg::SHIFT_A);
    x2 = x1 ^ (x1 >> xbr_pkg::SHIFT_B);
    x3 = x2 ^ (x2 << xbr_pkg::SHIFT_C);
  end

  // A bound fits in 32 signed bits when bits 63 down to 31 all agree.
  always_comb begin
    lo64   = (bound_count == xbr_pkg::BC_BOTH) ? low_bound : 64'sd1;
    lo_ok  = (&lo64[63:31]) | ~(|lo64[63:31]);
    hi_ok  = (&high_bound[63:31]) | ~(|high_bound[63:31]);
    lo32   = lo64[31:0];
    hi32   = high_bound[31:0];
    span_c = {hi32[31], hi32} - {lo32[31], lo32} + 33'd1;
    chk      = xbr_pkg::ST_OK;
    need_div = 1'b0;
    unique case (bound_count) inside
      xbr_pkg::BC_RAW: begin
        chk = xbr_pkg::ST_OK;
      end
      xbr_pkg::BC_MANY: begin
        chk = xbr_pkg::ST_TOO_MANY;
      end
      xbr_pkg::BC_HIGH, xbr_pkg::BC_BOTH: begin
        if (!lo_ok || !hi_ok) begin
          chk = xbr_pkg::ST_RANGE;
        end else if ($signed(hi32) < $signed(lo32)) begin
          chk = xbr_pkg::ST_EMPTY;
        end else begin
          need_div = 1'b1;
        end
      end
      default: begin
        chk = xbr_pkg::ST_OK;
      end
    endcase
  end

  assign sts.need_div = need_div;

  // Restoring remainder step: the remainder always stays below the span.
  always_comb begin
    trial = {rem_r, xs_r[31]};
    ge    = (trial >= span_r);
    diff  = trial - span_r;
  end

  always_comb begin
    if (raw_r) begin
      result = {1'b0, xs_r};
    end else if (sts_r != xbr_pkg::ST_OK) begin
      result = '0;
    end else begin
      result = {low_r[31], low_r} + {1'b0, rem_r};
    end
  end

  always_comb begin
    gen_nxt = gen_r;
    if (cmd.seed_wr) begin
      gen_nxt = (seed == '0) ? 32'd1 : seed;
    end else if (cmd.load) begin
      gen_nxt = x3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= 32'd1;
    end else begin
      gen_r <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r   <= x3;
      rem_r  <= '0;
      low_r  <= lo32;
      span_r <= span_c;
      sts_r  <= chk;
      raw_r  <= (bound_count == xbr_pkg::BC_RAW);
    end else if (cmd.step) begin
      xs_r  <= {xs_r[30:0], 1'b0};
      rem_r <= ge ? diff[31:0] : trial[31:0];
    end
    if (cmd.emit) begin
      value_r  <= result;
      status_r <= sts_r;
    end
  end

  assign value  = $signed(value_r);
  assign status = status_r;

endmodule

>>> rtl/core/xorshift32_bounded_random_top.sv
// Bounded xorshift32 random source. Every transaction on the input channel
// advances the 32-bit xorshift generator (shifts 13 left, 17 right, 5 left; a
// zero state is first replaced by 0x6d2b79f5) and produces exactly one
// transaction on the output channel, even when the request fails. A bound
// count of 0 returns the raw draw, 1 returns a value in 1..high_bound and 2
// returns a value in low_bound..high_bound, computed as low plus the draw
// modulo the span. Status reports too many bounds, a bound outside signed
// 32-bit range or an empty interval; failed requests return value zero.
// Writing the seed on the configuration channel reloads the generator (zero
// becomes one). Timing: a raw draw or failed request goes straight from the
// input transaction to the hold state; a bounded draw first runs the 32-step
// bit-serial remainder unit, which handles one draw bit per cycle. The hold
// state loads the output register once any earlier result has been claimed;
// output valid rises in the cycle after, and input ready returns in the same
// cycle. The block works on one request at a time; a finished result waits in
// an output register, so the next request can be taken while it is unclaimed.
module xorshift32_bounded_random_top (
  input logic        clk,
  input logic        rst_n,
  xbr_in_if.sink     in_if,
  xbr_out_if.source  out_if,
  xbr_cfg_if.sink    cfg_if
);

  // Commands from the controller and status back from the datapath.
  xbr_pkg::cmd_t cmd;
  xbr_pkg::sts_t sts;

  // The controller sequences accept, the remainder steps and the output
  // register; it owns every handshake signal.
  xbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the generator state, the bound checks, the remainder
  // unit and the output payload register.
  xbr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .bound_count (in_if.bound_count),
    .low_bound   (in_if.low_bound),
    .high_bound  (in_if.high_bound),
    .seed        (cfg_if.seed),
    .value       (out_if.value),
    .status      (out_if.status)
  );

  // Once a request is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input ready high right after an accepted request");

  // A failed request always reports a zero value.
  a_fail_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != xbr_pkg::ST_OK) |-> (out_if.value == '0))
    else $error("nonzero value on a failed request");

  // A result is only offered while no new request is being accepted in the
  // same cycle that the result register is loaded.
  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_if.ready)
    else $error("result loaded while the block was idle");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the bounded xorshift32 random source.
//
// A clocked driver offers request transactions from a queue that the main
// sequence fills. A clocked monitor compares every result transaction with
// the oldest predicted result. The prediction is made here: the bench keeps
// its own copy of the generator state, advances it on every accepted request
// and reduces the draw into the requested range. Seed writes happen only
// while nothing is in flight, so the prediction stays in step with the block.
module testbench;

  // Cycles without any transaction before the run is declared hung. The
  // longest legal quiet stretch is the forced receiver hold-off plus a
  // bounded draw, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD        = 300;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned RANDOM_PER_PHASE = 245;

  localparam longint INT32_LO = -64'sd2147483648;
  localparam longint INT32_HI = 64'sd2147483647;

  typedef struct packed {
    logic [1:0]         bound_count;
    logic signed [63:0] low_bound;
    logic signed [63:0] high_bound;
  } draw_req_t;

  typedef struct packed {
    logic signed [32:0] value;
    logic [1:0]         status;
  } draw_res_t;

  logic clk;
  logic rst_n;

  xbr_in_if  in_if();
  xbr_out_if out_if();
  xbr_cfg_if cfg_if();

  xorshift32_bounded_random_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Requests waiting to be offered and results waiting to arrive.
  draw_req_t   pending_reqs[$];
  draw_res_t   expected_results[$];

  // Bench copy of the generator state.
  logic [31:0] draw_state;

  // Idle and stall probabilities in percent, set per phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off: the sequence raises holds_asked, the ready
  // process serves it and counts the hold down on its own.
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  int accepted_reqs   = 0;
  int checked_results = 0;
  int seed_loads      = 0;
  int mismatches      = 0;
  int status_tally[4] = '{0, 0, 0, 0};
  int stall_cycles    = 0;

  // One step of the xorshift32 generator; a zero state is swapped for the
  // fixed substitute before shifting.
  function automatic logic [31:0] xorshift_next(input logic [31:0] s);
    logic [31:0] x;
    x = (s == 32'd0) ? xbr_pkg::ZERO_SUBST : s;
    x = x ^ (x << xbr_pkg::SHIFT_A);
    x = x ^ (x >> xbr_pkg::SHIFT_B);
    x = x ^ (x << xbr_pkg::SHIFT_C);
    return x;
  endfunction

  // Turns a fresh draw and a request into the result the block must return.
  function automatic draw_res_t reduce_draw(input logic [31:0] draw, input draw_req_t req);
    draw_res_t         res;
    longint            lo;
    longint            hi;
    longint unsigned   span;
    longint unsigned   rem;
    res.value  = '0;
    res.status = xbr_pkg::ST_OK;
    // With only a high bound the range starts at one.
    lo = (req.bound_count == xbr_pkg::BC_BOTH) ? $signed(req.low_bound) : 64'sd1;
    hi = $signed(req.high_bound);
    case (req.bound_count)
      xbr_pkg::BC_RAW: begin
        res.value = {1'b0, draw};
      end
      xbr_pkg::BC_MANY: begin
        res.status = xbr_pkg::ST_TOO_MANY;
      end
      default: begin
        if (lo < INT32_LO || lo > INT32_HI || hi < INT32_LO || hi > INT32_HI) begin
          res.status = xbr_pkg::ST_RANGE;
        end else if (hi < lo) begin
          res.status = xbr_pkg::ST_EMPTY;
        end else begin
          // The span reaches 2^32 for the full signed 32-bit interval.
          span      = longint'(hi - lo) + 64'd1;
          rem       = {32'd0, draw} % span;
          res.value = 33'(lo + longint'(rem));
        end
      end
    endcase
    return res;
  endfunction

  function automatic draw_req_t build_req(input logic [1:0] bc, input longint lo,
                                          input longint hi);
    draw_req_t req;
    req.bound_count = bc;
    req.low_bound   = lo;
    req.high_bound  = hi;
    return req;
  endfunction

  // Random request mix. On average 45 percent of requests are well-formed bounded
  // draws with small spans; the rest cover huge spans, empty intervals, bounds outside
  // signed 32-bit, raw draws and too many bounds. Unused bound fields carry
  // random 64-bit noise so that every bit toggles.
  function automatic draw_req_t random_request();
    draw_req_t req;
    int        pick;
    int        sub;
    int        lo32;
    int        hi32;
    req.bound_count = xbr_pkg::BC_RAW;
    req.low_bound   = {$urandom, $urandom};
    req.high_bound  = {$urandom, $urandom};
    pick = $urandom_range(99);
    sub  = $urandom_range(9);
    if (pick < 15) begin
      req.bound_count = xbr_pkg::BC_RAW;
    end else if (pick < 45) begin
      req.bound_count = xbr_pkg::BC_HIGH;
      if (sub < 6) begin
        hi32 = $urandom_range(1000, 1);
      end else if (sub == 6) begin
        hi32 = $urandom >> 1;
      end else if (sub == 7) begin
        hi32 = $urandom;
      end else begin
        hi32 = $urandom_range(50);
        hi32 = -hi32;
      end
      // One case in ten keeps the wide random high bound, mostly out of range.
      if (sub != 8) begin
        req.high_bound = hi32;
      end
    end else if (pick < 90) begin
      req.bound_count = xbr_pkg::BC_BOTH;
      if (sub < 6) begin
        lo32 = $urandom_range(2000);
        lo32 = lo32 - 1000;
        hi32 = $urandom_range(500);
        hi32 = lo32 + hi32;
      end else if (sub == 6) begin
        lo32 = $urandom;
        hi32 = $urandom;
      end else if (sub == 7) begin
        lo32 = $urandom_range(3);
        lo32 = lo32 - 2147483647 - 1;
        hi32 = $urandom_range(3);
        hi32 = 2147483647 - hi32;
      end else begin
        hi32 = $urandom_range(1000);
        hi32 = hi32 - 500;
        lo32 = $urandom_range(50, 1);
        lo32 = hi32 + lo32;
      end
      if (sub != 8) begin
        req.low_bound  = lo32;
        req.high_bound = hi32;
      end else if ($urandom_range(1) == 0) begin
        req.low_bound = lo32;
      end else begin
        req.high_bound = hi32;
      end
    end else begin
      req.bound_count = xbr_pkg::BC_MANY;
    end
    return req;
  endfunction

  // Clock and reset: reset is held low at the start and never asserted again.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver. On every accepted transaction the state is advanced and
  // the expected result queued; a new request is offered only once the
  // previous one has been taken, so valid is never dropped under a request.
  always @(posedge clk) begin : drive_requests
    draw_req_t next_req;
    draw_req_t taken;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      draw_state = 32'd1;
    end else begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        taken.bound_count = in_if.bound_count;
        taken.low_bound   = in_if.low_bound;
        taken.high_bound  = in_if.high_bound;
        draw_state = xorshift_next(draw_state);
        expected_results.push_back(reduce_draw(draw_state, taken));
        accepted_reqs++;
      end
      if (in_if.valid !== 1'b1 || in_if.ready === 1'b1) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_if.bound_count <= next_req.bound_count;
          in_if.low_bound   <= next_req.low_bound;
          in_if.high_bound  <= next_req.high_bound;
          in_if.valid       <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls per phase, plus the long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: every result transaction is matched with the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_results
    draw_res_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, value %0d status %0d", $time,
                 out_if.value, out_if.status);
      end else begin
        want = expected_results.pop_front();
        checked_results++;
        if (out_if.value !== want.value) begin
          mismatches++;
          $display("%0t: value mismatch, expected %0d (0x%h), actual %0d (0x%h)", $time,
                   want.value, want.value, out_if.value, out_if.value);
        end
        if (out_if.status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.status, out_if.status);
        end else begin
          status_tally[want.status]++;
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("testbench: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Blocks until every queued request was taken and every result arrived.
  // Returns just after a rising edge.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_if.valid === 1'b1 ||
           expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Seed write; the block must be idle. A zero seed loads one.
  task automatic load_seed(input logic [31:0] seed_val);
    cfg_if.seed  <= seed_val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    draw_state = (seed_val == 32'd0) ? 32'd1 : seed_val;
    seed_loads++;
    cfg_if.valid <= 1'b0;
  endtask

  // One phase: reseed while idle, set the idling mix, queue random requests.
  // With long_hold the receiver stops for a long stretch while the whole
  // phase is already queued, so the block backs up into its input. With
  // mid_pause the sender stops halfway until every result is back.
  task automatic run_phase(input logic [31:0] seed_val, input int send_pct,
                           input int recv_pct, input bit long_hold, input bit mid_pause);
    wait_drained();
    load_seed(seed_val);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (mid_pause && i == RANDOM_PER_PHASE / 2) begin
        wait_drained();
      end
      pending_reqs.push_back(random_request());
    end
    if (long_hold) begin
      holds_asked++;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.bound_count = xbr_pkg::BC_RAW;
    in_if.low_bound   = '0;
    in_if.high_bound  = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.seed       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests against the reset seed, no idling.
    pending_reqs.push_back(build_req(xbr_pkg::BC_RAW, 0, 0));
    pending_reqs.push_back(build_req(xbr_pkg::BC_RAW, -64'sd1, -64'sd1));
    // High bound only: smallest range, largest range, empty and out of range.
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 0, 1));
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 0, INT32_HI));
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 0, 0));
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 0, INT32_LO));
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 0, INT32_HI + 1));
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 0, INT32_LO - 1));
    // The low bound is ignored with a single bound, even when out of range.
    pending_reqs.push_back(build_req(xbr_pkg::BC_HIGH, 64'sh8000_0000_0000_0000, 100));
    // Two bounds: full 32-bit span, single-value ranges at both ends, a small range, empty and out of range.
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_LO, INT32_HI));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_LO, INT32_LO));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_HI, INT32_HI));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, -10, 10));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, 5, 4));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_HI, INT32_LO));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_HI + 1, INT32_HI + 2));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_LO - 1, 0));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, 0, 64'sh7fff_ffff_ffff_ffff));
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, 64'sh8000_0000_0000_0000, 0));
    // The range check wins over the empty-interval check.
    pending_reqs.push_back(build_req(xbr_pkg::BC_BOTH, INT32_HI + 1, INT32_LO - 1));
    // Too many bounds, whatever the bounds are.
    pending_reqs.push_back(build_req(xbr_pkg::BC_MANY, 1, 10));
    pending_reqs.push_back(build_req(xbr_pkg::BC_MANY, 64'sh7fff_ffff_ffff_ffff,
                                     64'sh8000_0000_0000_0000));
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      pending_reqs.push_back(random_request());
    end

    // Seeds include zero and both ends of the 32-bit range.
    run_phase(32'd0,         0,  0,  1'b1, 1'b0);
    run_phase(32'hFFFF_FFFF, 80, 0,  1'b0, 1'b0);
    run_phase($urandom,      0,  80, 1'b0, 1'b0);
    run_phase(32'h8000_0000, 22, 22, 1'b0, 1'b1);
    run_phase($urandom,      0,  0,  1'b0, 1'b0);
    run_phase(32'd1,         22, 22, 1'b0, 1'b0);

    wait_drained();
    // A late extra result from the block would still be caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("testbench: %0d requests, %0d results checked, %0d seed loads",
             accepted_reqs, checked_results, seed_loads);
    $display("testbench: status ok %0d, too many %0d, range %0d, empty %0d",
             status_tally[xbr_pkg::ST_OK], status_tally[xbr_pkg::ST_TOO_MANY],
             status_tally[xbr_pkg::ST_RANGE], status_tally[xbr_pkg::ST_EMPTY]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/xbr_pkg.sv
rtl/core/xbr_in_if.sv
rtl/core/xbr_out_if.sv
rtl/core/xbr_cfg_if.sv
rtl/core/xbr_ctrl.sv
rtl/core/xbr_dp.sv
rtl/core/xorshift32_bounded_random_top.sv
verif/testbench.sv
